/* hw/rtl/assert_macros.svh */
// Assertion macros used by the peer table update unit.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
// Checked at every rising clock edge while reset is low.
`define ASSERT_CLK(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// Checked at every rising clock edge, during reset as well.
`define ASSERT_ALWAYS(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define ASSERT_CLK(lbl, clk, rst, prop, msg)
`define ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif

`endif

/* hw/rtl/ptu_pkg.sv */
// Package with constants, word types and state codes of the peer table unit.
`default_nettype none

package ptu_pkg;

   localparam int TABLE_ENTRIES = 8;
   localparam int IDX_W  = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
   localparam int CNT_W  = $clog2(TABLE_ENTRIES + 1);
   localparam int SLOT_W = 3;

   typedef enum logic [1:0] {
      ST_IGNORED  = 2'd0,
      ST_REFRESH  = 2'd1,
      ST_FILLED   = 2'd2,
      ST_REPLACED = 2'd3
   } ptu_status_type;

   typedef enum logic [1:0] {
      S_IDLE,
      S_SCAN,
      S_FETCH,
      S_COMMIT
   } ptu_state_type;

   typedef struct packed {
      logic [63:0] name_hi;
      logic [63:0] name_lo;
      logic [1:0]  stress;
      logic        address_present;
      logic [63:0] address_hi;
      logic [63:0] address_lo;
      logic [31:0] timestamp;
   } ptu_req_type;

   typedef struct packed {
      ptu_status_type      status;
      logic [SLOT_W-1:0]   slot_index;
   } ptu_rsp_type;

   typedef struct packed {
      logic [63:0] name_hi;
      logic [63:0] name_lo;
      logic [63:0] address_hi;
      logic [63:0] address_lo;
      logic [1:0]  stress;
      logic [31:0] last_seen;
   } ptu_entry_type;

   localparam int ENTRY_W = $bits(ptu_entry_type);

endpackage

`default_nettype wire

/* hw/rtl/ptu_ram.sv */
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module ptu_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 8
) (
   input  wire logic                                       clock,
   input  wire logic                                       wr_en,
   input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]                           wr_data,
   input  wire logic                                       rd_en,
   input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic      [WIDTH-1:0]                           rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

/* hw/rtl/peer_table_update_oldest_replace_unit.sv */
// Peer table: refresh, fill or replace of the oldest entry; empty names are ignored.
//
//   channel  direction  word type     handshake
//   req      in         ptu_req_type  req_valid / req_stall
//   rsp      out        ptu_rsp_type  rsp_valid / rsp_stall
//
// An update with an empty name goes from acceptance straight to the commit step.
// Otherwise the table RAM is read one entry per cycle until a name match or the
// end, then the chosen entry is read once more and written back merged.
// Reset clears the valid bits and the control state; the RAM contents are not cleared.
// A new word is taken only in idle; a stalled result holds the commit step.
`default_nettype none
`include "assert_macros.svh"

module peer_table_update_oldest_replace_unit
   import ptu_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire ptu_req_type req_data,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output ptu_rsp_type      rsp_data
);

   ptu_state_type state_ff, state_in;
   ptu_req_type   req_ff, req_in;
   ptu_status_type status_ff, status_in;
   logic [IDX_W-1:0] sel_slot_ff, sel_slot_in;
   logic [CNT_W-1:0] rd_cnt_ff, rd_cnt_in;
   logic             chk_vld_ff, chk_vld_in;
   logic [IDX_W-1:0] chk_idx_ff, chk_idx_in;
   logic             have_free_ff, have_free_in;
   logic [IDX_W-1:0] free_slot_ff, free_slot_in;
   logic             have_old_ff, have_old_in;
   logic [IDX_W-1:0] old_slot_ff, old_slot_in;
   logic [31:0]      oldest_ff, oldest_in;
   logic [TABLE_ENTRIES-1:0] valid_ff, valid_in;
   logic             rsp_valid_ff, rsp_valid_in;
   ptu_rsp_type      rsp_ff, rsp_in;

   logic             req_fire;
   logic             commit_fire;
   logic             name_empty;
   logic             scan_hit;
   logic             scan_last;
   logic             scan_done;
   ptu_entry_type    ram_rdata;
   logic [ENTRY_W-1:0] ram_rdata_bits;
   ptu_entry_type    ram_wdata;
   logic             ram_wr_en;
   logic             ram_rd_en;
   logic [IDX_W-1:0] ram_rd_addr;

   assign req_fire    = req_valid && !req_stall;
   assign commit_fire = (state_ff == S_COMMIT) && (!rsp_valid_ff || !rsp_stall);
   assign name_empty  = (req_data.name_hi[63:56] == 8'd0);
   assign ram_rdata   = ptu_entry_type'(ram_rdata_bits);

   assign scan_hit  = chk_vld_ff && valid_ff[chk_idx_ff]
                      && (ram_rdata.name_hi == req_ff.name_hi)
                      && (ram_rdata.name_lo == req_ff.name_lo);
   assign scan_last = chk_vld_ff && (chk_idx_ff == IDX_W'(TABLE_ENTRIES - 1));
   assign scan_done = (state_ff == S_SCAN) && (scan_hit || scan_last);

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               state_in = name_empty ? S_COMMIT : S_SCAN;
            end
         end
         S_SCAN: begin
            if (scan_done) begin
               state_in = S_FETCH;
            end
         end
         S_FETCH: begin
            state_in = S_COMMIT;
         end
         S_COMMIT: begin
            if (commit_fire) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_comb begin
      req_stall    = (state_ff != S_IDLE);
      req_in       = req_ff;
      status_in    = status_ff;
      sel_slot_in  = sel_slot_ff;
      rd_cnt_in    = rd_cnt_ff;
      chk_vld_in   = 1'b0;
      chk_idx_in   = chk_idx_ff;
      have_free_in = have_free_ff;
      free_slot_in = free_slot_ff;
      have_old_in  = have_old_ff;
      old_slot_in  = old_slot_ff;
      oldest_in    = oldest_ff;
      valid_in     = valid_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      ram_rd_en    = 1'b0;
      ram_rd_addr  = rd_cnt_ff[IDX_W-1:0];
      ram_wr_en    = 1'b0;
      ram_wdata.name_hi    = req_ff.name_hi;
      ram_wdata.name_lo    = req_ff.name_lo;
      ram_wdata.address_hi = req_ff.address_present ? req_ff.address_hi
                                                    : ram_rdata.address_hi;
      ram_wdata.address_lo = req_ff.address_present ? req_ff.address_lo
                                                    : ram_rdata.address_lo;
      ram_wdata.stress     = req_ff.stress;
      ram_wdata.last_seen  = req_ff.timestamp;

      unique case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               req_in       = req_data;
               status_in    = ST_IGNORED;
               sel_slot_in  = '0;
               rd_cnt_in    = '0;
               have_free_in = 1'b0;
               have_old_in  = 1'b0;
            end
         end
         S_SCAN: begin
            if (rd_cnt_ff < CNT_W'(TABLE_ENTRIES)) begin
               ram_rd_en  = 1'b1;
               rd_cnt_in  = rd_cnt_ff + 1'b1;
               chk_vld_in = 1'b1;
               chk_idx_in = rd_cnt_ff[IDX_W-1:0];
            end
            if (chk_vld_ff) begin
               if (valid_ff[chk_idx_ff]) begin
                  if (!have_old_ff || (ram_rdata.last_seen < oldest_ff)) begin
                     have_old_in = 1'b1;
                     old_slot_in = chk_idx_ff;
                     oldest_in   = ram_rdata.last_seen;
                  end
               end else if (!have_free_ff) begin
                  have_free_in = 1'b1;
                  free_slot_in = chk_idx_ff;
               end
            end
            if (scan_hit) begin
               status_in   = ST_REFRESH;
               sel_slot_in = chk_idx_ff;
               chk_vld_in  = 1'b0;
            end else if (scan_last) begin
               status_in   = have_free_in ? ST_FILLED : ST_REPLACED;
               sel_slot_in = have_free_in ? free_slot_in : old_slot_in;
               chk_vld_in  = 1'b0;
            end
         end
         S_FETCH: begin
            ram_rd_en   = 1'b1;
            ram_rd_addr = sel_slot_ff;
         end
         S_COMMIT: begin
            if (commit_fire) begin
               rsp_valid_in      = 1'b1;
               rsp_in.status     = status_ff;
               rsp_in.slot_index = SLOT_W'(sel_slot_ff);
               if (status_ff != ST_IGNORED) begin
                  ram_wr_en             = 1'b1;
                  valid_in[sel_slot_ff] = 1'b1;
               end
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         valid_ff     <= '0;
         rsp_valid_ff <= 1'b0;
         chk_vld_ff   <= 1'b0;
      end else begin
         state_ff     <= state_in;
         valid_ff     <= valid_in;
         rsp_valid_ff <= rsp_valid_in;
         chk_vld_ff   <= chk_vld_in;
      end
      req_ff       <= req_in;
      status_ff    <= status_in;
      sel_slot_ff  <= sel_slot_in;
      rd_cnt_ff    <= rd_cnt_in;
      chk_idx_ff   <= chk_idx_in;
      have_free_ff <= have_free_in;
      free_slot_ff <= free_slot_in;
      have_old_ff  <= have_old_in;
      old_slot_ff  <= old_slot_in;
      oldest_ff    <= oldest_in;
      rsp_ff       <= rsp_in;
   end

   ptu_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (TABLE_ENTRIES)
   ) u_entry_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (sel_slot_ff),
      .wr_data (ram_wdata),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rdata_bits)
   );

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   `ASSERT_CLK(a_refresh_valid, clock, reset, (state_ff == S_COMMIT && status_ff == ST_REFRESH) |-> valid_ff[sel_slot_ff], "refresh of an invalid entry")
   `ASSERT_CLK(a_fill_free, clock, reset, (state_ff == S_COMMIT && status_ff == ST_FILLED) |-> !valid_ff[sel_slot_ff], "fill of an entry already in use")
   `ASSERT_CLK(a_replace_full, clock, reset, (state_ff == S_COMMIT && status_ff == ST_REPLACED) |-> (&valid_ff), "replacement while a free entry exists")
   `ASSERT_CLK(a_ignored_slot, clock, reset, (rsp_valid_ff && rsp_ff.status == ST_IGNORED) |-> (rsp_ff.slot_index == '0), "ignored word with nonzero slot")
   `ASSERT_CLK(a_rsp_from_commit, clock, reset, $rose(rsp_valid_ff) |-> ($past(state_ff) == S_COMMIT), "result word raised outside commit")

endmodule

`default_nettype wire

/* bench/tb.sv */
// Self-checking testbench for the peer table update unit with oldest-entry replacement.
module tb;
   import ptu_pkg::*;

   localparam int UPDATE_COUNT = 1500;
   localparam int POOL_SIZE = 12;
   localparam int QUIET_LIMIT = 5000;
   localparam int LONG_HOLD = 300;
   localparam int LONG_HOLD_AT = 400;
   localparam int DRAIN_PERIOD = 300;
   localparam int SETTLE_CYCLES = 3 * (TABLE_ENTRIES + 4);
   localparam logic [31:0] TIME_MAX = 32'hFFFF_FFFF;

   typedef struct {
      ptu_req_type word;
      int unsigned gap;
      bit drain;
   } update_item_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   ptu_req_type req_data = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   ptu_rsp_type rsp_data;

   update_item_type pending_updates[$];
   ptu_rsp_type expected_outcomes[$];
   int unsigned mismatch_count = 0;
   int unsigned send_wait = 0;
   int unsigned hold_left = 0;
   int unsigned outcomes_seen = 0;
   int unsigned quiet_cycles = 0;
   bit quick_accept = 1'b0;
   ptu_rsp_type head_outcome;

   logic        peer_valid [TABLE_ENTRIES];
   logic [63:0] peer_name_hi [TABLE_ENTRIES];
   logic [63:0] peer_name_lo [TABLE_ENTRIES];
   logic [63:0] peer_addr_hi [TABLE_ENTRIES];
   logic [63:0] peer_addr_lo [TABLE_ENTRIES];
   logic [1:0]  peer_level [TABLE_ENTRIES];
   logic [31:0] peer_last_seen [TABLE_ENTRIES];

   logic [63:0] pool_hi [POOL_SIZE];
   logic [63:0] pool_lo [POOL_SIZE];

   peer_table_update_oldest_replace_unit DUT (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_data(req_data),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_data(rsp_data)
   );

   always #6 clock = ~clock;

   function automatic ptu_rsp_type apply_peer_update(input ptu_req_type w);
      ptu_rsp_type r;
      int match_k = -1;
      int free_k = -1;
      int old_k = -1;
      int k;
      r.status = ST_IGNORED;
      r.slot_index = '0;
      if (w.name_hi[63:56] == 8'h00) return r;
      for (k = 0; k < TABLE_ENTRIES; k++) begin
         if (peer_valid[k]) begin
            if (match_k < 0 && peer_name_hi[k] == w.name_hi && peer_name_lo[k] == w.name_lo)
               match_k = k;
            if (old_k < 0 || peer_last_seen[k] < peer_last_seen[old_k])
               old_k = k;
         end else if (free_k < 0) begin
            free_k = k;
         end
      end
      if (match_k >= 0) begin
         r.status = ST_REFRESH;
         k = match_k;
      end else if (free_k >= 0) begin
         r.status = ST_FILLED;
         k = free_k;
      end else begin
         r.status = ST_REPLACED;
         k = old_k;
      end
      if (r.status != ST_REFRESH) begin
         peer_valid[k] = 1'b1;
         peer_name_hi[k] = w.name_hi;
         peer_name_lo[k] = w.name_lo;
      end
      peer_level[k] = w.stress;
      peer_last_seen[k] = w.timestamp;
      if (w.address_present) begin
         peer_addr_hi[k] = w.address_hi;
         peer_addr_lo[k] = w.address_lo;
      end
      r.slot_index = SLOT_W'(k);
      return r;
   endfunction

   function automatic void queue_update(input logic [63:0] nh, input logic [63:0] nl,
                                        input logic [1:0] st, input logic ap,
                                        input logic [63:0] ah, input logic [63:0] al,
                                        input logic [31:0] ts, input int unsigned gap,
                                        input bit drain);
      update_item_type u;
      u.word.name_hi = nh;
      u.word.name_lo = nl;
      u.word.stress = st;
      u.word.address_present = ap;
      u.word.address_hi = ah;
      u.word.address_lo = al;
      u.word.timestamp = ts;
      u.gap = gap;
      u.drain = drain;
      pending_updates.push_back(u);
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         send_wait <= 0;
      end else begin
         if (req_valid && !req_stall)
            expected_outcomes.push_back(apply_peer_update(req_data));
         if (!req_valid || !req_stall) begin
            if (pending_updates.size() == 0) begin
               req_valid <= 1'b0;
            end else if (send_wait < pending_updates[0].gap) begin
               req_valid <= 1'b0;
               send_wait <= send_wait + 1;
            end else if (pending_updates[0].drain && expected_outcomes.size() != 0) begin
               req_valid <= 1'b0;
            end else begin
               req_data <= pending_updates[0].word;
               req_valid <= 1'b1;
               send_wait <= 0;
               void'(pending_updates.pop_front());
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset) begin
         hold_left = 0;
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_outcomes.size() == 0) begin
               $error("unexpected result: status %0d slot_index %0d",
                      rsp_data.status, rsp_data.slot_index);
               mismatch_count++;
            end else begin
               head_outcome = expected_outcomes.pop_front();
               if (rsp_data.status !== head_outcome.status) begin
                  $error("status: expected %0d, actual %0d",
                         head_outcome.status, rsp_data.status);
                  mismatch_count++;
               end
               if (rsp_data.slot_index !== head_outcome.slot_index) begin
                  $error("slot_index: expected %0d, actual %0d",
                         head_outcome.slot_index, rsp_data.slot_index);
                  mismatch_count++;
               end
            end
            outcomes_seen++;
            if (outcomes_seen % 64 == 0)
               quick_accept = ($urandom_range(0, 2) == 0);
            if (outcomes_seen == LONG_HOLD_AT)
               hold_left = LONG_HOLD;
            else
               hold_left = quick_accept ? 0 : $urandom_range(0, 19);
         end else if (hold_left != 0) begin
            hold_left--;
         end
         rsp_stall <= (hold_left != 0);
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
         $display("FAIL peer_table_update_oldest_replace_unit");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      int k;
      int pick;
      bit quick_send;
      logic [63:0] nh;
      logic [63:0] nl;
      logic [31:0] ts;

      for (k = 0; k < TABLE_ENTRIES; k++)
         peer_valid[k] = 1'b0;

      // Name pool in which every third name differs from the one before it in one bit of the low half.
      for (k = 0; k < POOL_SIZE; k++) begin
         if (k % 3 == 1) begin
            pool_hi[k] = pool_hi[k - 1];
            pool_lo[k] = pool_lo[k - 1] ^ (64'h1 << $urandom_range(0, 63));
         end else begin
            pool_hi[k] = {8'($urandom_range(1, 255)), 24'($urandom), $urandom};
            pool_lo[k] = {$urandom, $urandom};
         end
      end

      queue_update('0, '1, 2'd2, 1'b1, '1, '1, TIME_MAX, 0, 1'b0);
      queue_update(64'h00FF_FFFF_FFFF_FFFF, '1, 2'd1, 1'b0, '0, '0, '0, 3, 1'b0);
      queue_update(64'h0100_0000_0000_0000, 64'h0, 2'd0, 1'b1, '0, '0, TIME_MAX, 0, 1'b0);
      queue_update(64'h0100_0000_0000_0000, 64'h1, 2'd1, 1'b0, '1, '1, TIME_MAX, 5, 1'b0);
      queue_update('1, 64'hFFFF_FFFF_FFFF_FFFE, 2'd2, 1'b1, '1, '0, TIME_MAX, 0, 1'b0);
      queue_update(64'h7065_6572_0000_0000, 64'h0, 2'd0, 1'b0, '0, '1, TIME_MAX, 19, 1'b0);
      queue_update(64'h0100_0000_0000_0001, 64'h0, 2'd1, 1'b1, 64'h3130_2E30_2E30_2E31,
                   64'h0, TIME_MAX, 0, 1'b0);
      queue_update(64'h8000_0000_0000_0000, 64'h8000_0000_0000_0000, 2'd2, 1'b0, '0, '0,
                   TIME_MAX, 1, 1'b0);
      queue_update(64'hAAAA_AAAA_AAAA_AAAA, 64'h5555_5555_5555_5555, 2'd0, 1'b1,
                   64'h5555_5555_5555_5555, 64'hAAAA_AAAA_AAAA_AAAA, TIME_MAX, 0, 1'b0);
      queue_update('1, '1, 2'd1, 1'b0, '0, '0, TIME_MAX, 0, 1'b0);
      // Full table with every time at maximum: the lowest entry goes.
      queue_update(64'h6E65_7770_6565_7200, 64'h0, 2'd2, 1'b1, '1, '1, TIME_MAX, 2, 1'b0);
      queue_update(64'h7065_6572_0000_0000, 64'h0, 2'd1, 1'b0, '1, '1, 32'h0, 0, 1'b0);
      queue_update('1, '1, 2'd2, 1'b1, '1, '1, 32'h1, 0, 1'b0);
      queue_update(64'h6C61_7465_0000_0000, 64'h0, 2'd0, 1'b1, '0, '0, 32'h5, 7, 1'b0);
      queue_update(64'h0100_0000_0000_0000, 64'h1, 2'd2, 1'b0, '0, '0, 32'h5, 0, 1'b0);
      queue_update(64'h0100_0000_0000_0000, 64'h0, 2'd1, 1'b1, '1, '0, TIME_MAX, 0, 1'b0);
      queue_update(64'h7072_6F62_6500_0000, 64'h0, 2'd0, 1'b0, '0, '0, TIME_MAX, 0, 1'b1);

      quick_send = 1'b0;
      for (k = 0; k < UPDATE_COUNT; k++) begin
         if (k % 100 == 0)
            quick_send = ($urandom_range(0, 3) == 0);
         pick = $urandom_range(0, 99);
         if (pick < 6) begin
            nh = {8'h00, 24'($urandom), $urandom};
            nl = {$urandom, $urandom};
         end else if (pick < 16) begin
            nh = {$urandom, $urandom};
            nl = {$urandom, $urandom};
         end else begin
            pick = $urandom_range(0, POOL_SIZE - 1);
            nh = pool_hi[pick];
            nl = pool_lo[pick];
         end
         case ($urandom_range(0, 9))
            0, 1, 2, 3, 4: ts = $urandom_range(0, 15);
            5: ts = TIME_MAX;
            6: ts = TIME_MAX - $urandom_range(0, 3);
            default: ts = $urandom;
         endcase
         queue_update(nh, nl, 2'($urandom_range(0, 2)), 1'($urandom_range(0, 1)),
                      {$urandom, $urandom}, {$urandom, $urandom}, ts,
                      quick_send ? 0 : $urandom_range(0, 19), (k % DRAIN_PERIOD) == 150);
      end

      repeat (6) @(posedge clock);
      reset <= 1'b0;
      while (pending_updates.size() != 0 || req_valid || expected_outcomes.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (mismatch_count == 0)
         $display("PASS peer_table_update_oldest_replace_unit");
      else
         $display("FAIL peer_table_update_oldest_replace_unit");
      $finish;
   end

endmodule
